// ----- hw/rtl/property_ratio_similarity_core_assert.svh -----
// Assertion macros for the property ratio similarity core.
// Define NO_ASSERTIONS to compile them away.
`ifndef PROPERTY_RATIO_SIMILARITY_CORE_ASSERT_SVH
`define PROPERTY_RATIO_SIMILARITY_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PRS_ASSERT(label, prop, msg)
`define PRS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ----- hw/rtl/prs_pkg.sv -----
// Package for the property ratio similarity core: widths and shared types.
// No dependencies.
`timescale 1ns / 1ps
package prs_pkg;
    localparam int LANES      = 8;
    localparam int MAX_CHUNKS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = 8;
    localparam int SCORE_W    = FRAC_BITS + 1;
    localparam int CHUNK_W    = $clog2(MAX_CHUNKS + 1);
    localparam int LSUM_W     = SCORE_W + $clog2(LANES);
    localparam int SUM_W      = LSUM_W + $clog2(MAX_CHUNKS);
    localparam int NUM_W      = VAL_W + FRAC_BITS;
    localparam int QCNT_W     = $clog2(NUM_W + 1);
    localparam int DIV_W      = SUM_W;
    localparam int DCNT_W     = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_LANE, ST_MEAN, ST_OUT} state_t;

    typedef struct packed {
        logic start;
        logic done;
    } lane_ctl_t;
endpackage

// ----- hw/rtl/prs_lane.sv -----
// One lane: restoring divider for floor(min * 2^FRAC_BITS / max), one bit per cycle.
// Equal values score 1.0, otherwise a zero value scores 0.5. Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [prs_pkg::VAL_W-1:0]    a,
    input  logic [prs_pkg::VAL_W-1:0]    b,
    output logic                         done,
    output logic [prs_pkg::SCORE_W-1:0]  score
);
    import prs_pkg::*;

    logic [VAL_W-1:0]   hi_reg;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [VAL_W:0]     rem_reg, rem_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [1:0]         kind_reg;
    logic [VAL_W:0]     trial;

    localparam logic [1:0] K_ONE = 2'd0, K_HALF = 2'd1, K_DIV = 2'd2;

    always_comb
    begin
        trial = {rem_reg[VAL_W-1:0], quo_reg[NUM_W-1]};
        quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, hi_reg})
        begin
            rem_next = trial - {1'b0, hi_reg};
            quo_next[0] = 1'b1;
        end
        cnt_next = cnt_reg - 1'b1;
        busy_next = cnt_reg != QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (a != b) && (a != '0) && (b != '0);
            cnt_reg  <= QCNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg  <= (a < b) ? b : a;
            quo_reg <= {((a < b) ? a : b), {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            kind_reg <= (a == b) ? K_ONE : ((a == '0 || b == '0) ? K_HALF : K_DIV);
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = !busy_reg;

    always_comb
    begin
        case (kind_reg)
            K_ONE:   score = SCORE_W'(1) << FRAC_BITS;
            K_HALF:  score = SCORE_W'(1) << (FRAC_BITS - 1);
            default: score = {1'b0, quo_reg[FRAC_BITS-1:0]};
        endcase
    end
endmodule

// ----- hw/rtl/prs_merge.sv -----
// Merge stage: adds lane scores into the run sum and divides by 8*chunks for the mean.
// Depends on prs_pkg.
`timescale 1ns / 1ps
module prs_merge (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   add,
    input  logic [prs_pkg::LANES*prs_pkg::SCORE_W-1:0] scores,
    input  logic                                   start_mean,
    input  logic                                   clear,
    output prs_pkg::lane_ctl_t                     ctl,
    output logic [prs_pkg::SCORE_W-1:0]            mean,
    output logic [prs_pkg::CHUNK_W-1:0]            chunks
);
    import prs_pkg::*;

    logic [SUM_W-1:0]   sum_reg;
    logic [CHUNK_W-1:0] cnt_reg;
    logic [LSUM_W-1:0]  lane_sum;
    logic [DIV_W-1:0]   quo_reg;
    logic [DIV_W:0]     rem_reg, trial;
    logic [DIV_W-1:0]   dvs;
    logic [DCNT_W-1:0]  step_reg;
    logic               busy_reg;

    always_comb
    begin
        lane_sum = '0;
        for (int i = 0; i < LANES; i++)
            lane_sum = lane_sum + LSUM_W'(scores[i*SCORE_W +: SCORE_W]);
    end

    assign dvs   = DIV_W'(cnt_reg) << $clog2(LANES);
    assign trial = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (clear)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else if (add)
            begin
                sum_reg <= sum_reg + SUM_W'(lane_sum);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (start_mean)
            begin
                busy_reg <= 1'b1;
                step_reg <= DCNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                busy_reg <= step_reg != DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_mean)
        begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs})
            begin
                rem_reg <= trial - {1'b0, dvs};
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign ctl.start = start_mean;
    assign ctl.done  = !busy_reg && !start_mean;
    assign mean      = quo_reg[SCORE_W-1:0];
    assign chunks    = cnt_reg;
endmodule

// ----- hw/rtl/property_ratio_similarity_core.sv -----
// Property ratio similarity core: eight parallel ratio lanes plus a merging stage.
// Depends on prs_pkg, prs_lane, prs_merge and the assertion header.
//
// Use: present one chunk (eight byte pairs) per transaction on the input channel
// (in_valid / in_stall); last_chunk closes a run. One transaction leaves on the
// output channel (out_valid / out_stall) per run, on its last chunk, carrying
// the mean lane score in Q1.16 and the too_long flag.
// Timing: a chunk is taken only while the core is idle. When some lane must divide
// (values differ, both nonzero) the lanes run 24 bit-serial steps and the next
// chunk can be taken once every lane is done; a chunk with no such lane, or one
// beyond MAX_CHUNKS, frees the input after a single pass through ST_LANE.
// A last chunk adds the mean: ST_MEAN loads the mean divider, which runs 25 steps,
// and ST_OUT then loads the output register (a too-long run skips ST_MEAN). The
// input is freed by the same edge that loads the output register and sets out_valid.
// While the receiver stalls the result holds; further chunks are still taken,
// but a later last chunk waits in its final cycle until the result leaves.
// Reset clears the run sum, chunk count, overflow flag and output valid.
`timescale 1ns / 1ps
`include "property_ratio_similarity_core_assert.svh"
module property_ratio_similarity_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [63:0]                     lhs_values,
    input  logic [63:0]                     rhs_values,
    input  logic                            last_chunk,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [prs_pkg::SCORE_W-1:0]     similarity,
    output logic                            too_long
);
    import prs_pkg::*;

    state_t state_reg, state_next;
    logic   last_reg, ovf_reg, skip_reg;
    logic   ovf_next;
    logic   out_valid_reg;
    logic   accept;
    logic   lane_start, add, start_mean, clear, load_out;
    logic [LANES-1:0] lane_done;
    logic [LANES*SCORE_W-1:0] scores;
    lane_ctl_t mctl;
    logic [SCORE_W-1:0] mean;
    logic [CHUNK_W-1:0] chunks;
    logic [SCORE_W-1:0] sim_reg;
    logic               tl_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign lane_start = accept && (chunks < CHUNK_W'(MAX_CHUNKS));

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            prs_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .start (lane_start),
                .a     (lhs_values[g*VAL_W +: VAL_W]),
                .b     (rhs_values[g*VAL_W +: VAL_W]),
                .done  (lane_done[g]),
                .score (scores[g*SCORE_W +: SCORE_W])
            );
        end
    endgenerate

    prs_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .add        (add),
        .scores     (scores),
        .start_mean (start_mean),
        .clear      (clear),
        .ctl        (mctl),
        .mean       (mean),
        .chunks     (chunks)
    );

    always_comb
    begin
        state_next = state_reg;
        add = 1'b0;
        start_mean = 1'b0;
        clear = 1'b0;
        load_out = 1'b0;
        ovf_next = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (!lane_start)
                        ovf_next = 1'b1;
                    state_next = ST_LANE;
                end
            ST_LANE:
                if (skip_reg || (&lane_done))
                begin
                    add = !skip_reg;
                    if (!last_reg)
                        state_next = ST_IDLE;
                    else if (ovf_reg)
                        state_next = ST_OUT;
                    else
                        state_next = ST_MEAN;
                end
            ST_MEAN:
                state_next = ST_OUT;
            ST_OUT:
                if (mctl.done && (!out_valid_reg || !out_stall))
                begin
                    load_out = 1'b1;
                    clear = 1'b1;
                    ovf_next = 1'b0;
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
        if (state_reg == ST_MEAN)
            start_mean = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovf_reg   <= ovf_next;
            if (accept)
            begin
                last_reg <= last_chunk;
                skip_reg <= !lane_start;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sim_reg <= ovf_reg ? '0 : mean;
            tl_reg  <= ovf_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign similarity = sim_reg;
    assign too_long   = tl_reg;

    `PRS_ASSERT(a_no_accept_busy, accept |-> state_reg == ST_IDLE, "chunk taken while busy")
    `PRS_ASSERT(a_count_bound, chunks <= CHUNK_W'(MAX_CHUNKS), "chunk count beyond limit")
    `PRS_ASSERT_NEXT(a_load_valid, load_out, out_valid, "result not presented")
    `PRS_ASSERT_NEXT(a_clear_run, clear, chunks == '0, "run state not cleared")
endmodule

// ----- tb/testbench.sv -----
// Testbench for property_ratio_similarity_core: directed table of chunks, then random runs.
// Checks every output transaction against a built-in predictor or a golden value from the table; depends on prs_pkg.
`timescale 1ns / 1ps
module testbench;
    import prs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [SCORE_W-1:0] sim;
        logic               long_run;
    } sim_result_t;

    typedef struct {
        logic [63:0]        lhs;
        logic [63:0]        rhs;
        logic               last;
        logic               has_golden;
        logic [SCORE_W-1:0] golden_sim;
        logic               golden_long;
    } chunk_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [63:0]         lhs_values = '0;
    logic [63:0]         rhs_values = '0;
    logic                last_chunk = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [SCORE_W-1:0]  similarity;
    logic                too_long;

    property_ratio_similarity_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .lhs_values(lhs_values), .rhs_values(rhs_values), .last_chunk(last_chunk),
        .out_valid(out_valid), .out_stall(out_stall),
        .similarity(similarity), .too_long(too_long)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [SUM_W-1:0]   run_sum;
    int unsigned        run_chunks;
    logic               run_over;
    sim_result_t        pending_scores[$];
    int                 error_count = 0;
    int                 send_idle_pct = 25;
    int                 recv_idle_pct = 69;
    bit                 hold_off = 1'b0;
    bit                 tx_done = 1'b0;

    function automatic logic [SCORE_W-1:0] ratio_score(logic [7:0] a, logic [7:0] b);
        logic [NUM_W-1:0] lo;
        logic [7:0]       hi;
        if (a == b)
            return SCORE_W'(1 << FRAC_BITS);
        if (a == 0 || b == 0)
            return SCORE_W'(1 << (FRAC_BITS - 1));
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return SCORE_W'((lo << FRAC_BITS) / hi);
    endfunction

    function automatic bit accumulate_chunk(logic [63:0] lhs, logic [63:0] rhs, logic last,
                                            output sim_result_t res);
        logic [SUM_W-1:0] total;
        total = '0;
        if (run_chunks >= MAX_CHUNKS)
            run_over = 1'b1;
        else
        begin
            for (int i = 0; i < LANES; i++)
                total += ratio_score(lhs[8*i +: 8], rhs[8*i +: 8]);
            run_sum += total;
            run_chunks++;
        end
        if (!last)
            return 1'b0;
        if (run_over)
        begin
            res.sim = '0;
            res.long_run = 1'b1;
        end
        else
        begin
            res.sim = SCORE_W'(run_sum / (LANES * run_chunks));
            res.long_run = 1'b0;
        end
        run_sum = '0;
        run_chunks = 0;
        run_over = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_scores.size() == 0)
                report_mismatch("unexpected transaction", similarity, -1);
            else
            begin
                sim_result_t want;
                want = pending_scores.pop_front();
                if (similarity !== want.sim)
                    report_mismatch("similarity", similarity, want.sim);
                if (too_long !== want.long_run)
                    report_mismatch("too_long", too_long, want.long_run);
            end
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_chunk(logic [63:0] lhs, logic [63:0] rhs, logic last);
        sim_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        lhs_values <= lhs;
        rhs_values <= rhs;
        last_chunk <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (accumulate_chunk(lhs, rhs, last, res))
            pending_scores.insert(pending_scores.size(), res);
    endtask

    function automatic logic [63:0] random_vector(int mode);
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(mode))
                0: v[8*i +: 8] = 8'd0;
                1: v[8*i +: 8] = 8'hFF;
                default: v[8*i +: 8] = 8'($urandom_range(255));
            endcase
        end
        return v;
    endfunction

    task automatic random_run(int max_len);
        int          n;
        logic [63:0] lhs;
        logic [63:0] rhs;
        n = $urandom_range(max_len, 1);
        for (int c = 0; c < n; c++)
        begin
            lhs = random_vector(4);
            case ($urandom_range(3))
                0: rhs = lhs;
                1: rhs = lhs ^ (64'h1 << $urandom_range(63));
                default: rhs = random_vector(4);
            endcase
            send_chunk(lhs, rhs, c == n - 1);
        end
    endtask

    chunk_row_t directed_rows[$];

    task automatic add_row(logic [63:0] l, logic [63:0] r, logic last, logic gold,
                           logic [SCORE_W-1:0] s, logic t);
        chunk_row_t row;
        row.lhs = l; row.rhs = r; row.last = last;
        row.has_golden = gold; row.golden_sim = s; row.golden_long = t;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    initial
    begin
        sim_result_t dummy;
        run_sum = '0;
        run_chunks = 0;
        run_over = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row('0, '0, 1'b1, 1'b1, 17'h10000, 1'b0);
        add_row({8{8'hFF}}, {8{8'hFF}}, 1'b1, 1'b1, 17'h10000, 1'b0);
        add_row('0, {8{8'hFF}}, 1'b1, 1'b1, 17'h08000, 1'b0);
        add_row({8{8'h01}}, {8{8'hFF}}, 1'b1, 1'b1, 17'd257, 1'b0);
        add_row({8{8'h80}}, {8{8'hFF}}, 1'b1, 1'b0, '0, 1'b0);
        add_row({8{8'hFF}}, {8{8'h7F}}, 1'b0, 1'b0, '0, 1'b0);
        add_row(64'h0102030405060708, 64'h0807060504030201, 1'b1, 1'b0, '0, 1'b0);
        add_row(64'hAAAA5555AAAA5555, 64'h5555AAAA5555AAAA, 1'b0, 1'b0, '0, 1'b0);
        add_row('0, {8{8'h01}}, 1'b1, 1'b0, '0, 1'b0);
        for (int i = 0; i < 33; i++)
            add_row({8{8'h10}}, {8{8'h20}}, i == 32, i == 32, '0, 1'b1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_golden)
            begin
                send_chunk(directed_rows[i].lhs, directed_rows[i].rhs, directed_rows[i].last);
                dummy = pending_scores.pop_back();
                dummy.sim = directed_rows[i].golden_sim;
                dummy.long_run = directed_rows[i].golden_long;
                pending_scores.insert(pending_scores.size(), dummy);
            end
            else
                send_chunk(directed_rows[i].lhs, directed_rows[i].rhs, directed_rows[i].last);
        end

        // fill up the block with a long receiver hold-off
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                random_run(2);
        join

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 25 : 0;
            for (int k = 0; k < 60; k++)
                random_run((k % 10 == 9) ? 36 : 5);
        end
        in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
